// ===== rtl/cbe_pkg.sv =====
// Package for the cubic Bezier easing evaluator.
// Holds the register index codes and the controller/datapath command type.
// No dependencies.
package cbe_pkg;

	localparam int RegIdxW = 3;

	typedef enum logic [RegIdxW-1:0] {
		REG_START_DELAY    = 3'd0,
		REG_SEGMENT_LENGTH = 3'd1,
		REG_CTRL1_X        = 3'd2,
		REG_CTRL1_Y        = 3'd3,
		REG_CTRL2_X        = 3'd4,
		REG_CTRL2_Y        = 3'd5
	} reg_idx_t;

	// datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_LOAD   = 3'd1,  // capture time, start progress division
		OP_DIVSTP = 3'd2,  // one restoring division step
		OP_PROG   = 3'd3,  // take quotient as progress, seed s
		OP_MUL    = 3'd4,  // one micro step of the polynomial sequence
		OP_NEWTON = 3'd5,  // take quotient as delta, update s
		OP_YOUT   = 3'd6   // clamp y and present it
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [4:0] mstep;   // micro step inside the polynomial sequence
		logic       y_pass;  // polynomial evaluated with y control points
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic dx_zero;
	} status_t;

endpackage

// ===== rtl/cbe_datapath.sv =====
// Datapath of the cubic Bezier easing evaluator: configuration registers,
// one shared multiplier, a bit-serial divider and the Newton variable.
// Depends on cbe_pkg.
module cbe_datapath #(
	parameter int FRAC_BITS = 16,
	parameter int TIME_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_idx,
	input  logic [31:0]            cfg_data,
	input  logic [TIME_BITS-1:0]   play_time,
	input  cbe_pkg::cmd_t          cmd,
	output cbe_pkg::status_t       status,
	output logic [FRAC_BITS:0]     progress
);

	localparam int XW = FRAC_BITS + 1;
	localparam int YW = FRAC_BITS + 2;
	// working width for Q values and sums
	localparam int VW = FRAC_BITS + 6;
	localparam int DW = TIME_BITS + FRAC_BITS + 8;  // dividend register
	localparam int QW = TIME_BITS + FRAC_BITS + 8;
	localparam logic signed [VW-1:0] One = VW'(1) <<< FRAC_BITS;
	localparam logic signed [2*VW-1:0] Half = (2*VW)'(1) <<< (FRAC_BITS - 1);

	logic [TIME_BITS-1:0] start_delay_q, segment_length_q;
	logic [XW-1:0]        ctrl1_x_q, ctrl2_x_q;
	logic [YW-1:0]        ctrl1_y_q, ctrl2_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delay_q    <= '0;
			segment_length_q <= TIME_BITS'(1);
			ctrl1_x_q        <= '0;
			ctrl1_y_q        <= '0;
			ctrl2_x_q        <= XW'(1) << FRAC_BITS;
			ctrl2_y_q        <= YW'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			case (cfg_idx)
				cbe_pkg::REG_START_DELAY:    start_delay_q    <= cfg_data[TIME_BITS-1:0];
				cbe_pkg::REG_SEGMENT_LENGTH: segment_length_q <= cfg_data[TIME_BITS-1:0];
				cbe_pkg::REG_CTRL1_X:        ctrl1_x_q        <= cfg_data[XW-1:0];
				cbe_pkg::REG_CTRL1_Y:        ctrl1_y_q        <= cfg_data[YW-1:0];
				cbe_pkg::REG_CTRL2_X:        ctrl2_x_q        <= cfg_data[XW-1:0];
				cbe_pkg::REG_CTRL2_Y:        ctrl2_y_q        <= cfg_data[YW-1:0];
				default: ;
			endcase
		end
	end

	// saturated x and sign-extended y coordinates
	logic signed [VW-1:0] p1x, p2x, p1y, p2y, c1, c2;
	always_comb begin
		p1x = (ctrl1_x_q > XW'(One)) ? One : VW'(ctrl1_x_q);
		p2x = (ctrl2_x_q > XW'(One)) ? One : VW'(ctrl2_x_q);
		p1y = VW'(signed'(ctrl1_y_q));
		p2y = VW'(signed'(ctrl2_y_q));
		c1  = cmd.y_pass ? p1y : p1x;
		c2  = cmd.y_pass ? p2y : p2x;
	end

	logic signed [VW-1:0] f_q, s_q, omt_q, a_q, b_q, c_q, t_q, acc_q, dx_q;

	// shared multiplier with rounding, operands chosen by micro step
	logic signed [VW-1:0] ma, mb, mr;
	logic signed [2*VW-1:0] mp, mabs;
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.mstep)
			5'd0:  begin ma = omt_q; mb = omt_q; end      // a
			5'd1:  begin ma = s_q;   mb = s_q;   end      // b
			5'd2:  begin ma = omt_q; mb = s_q;   end      // c
			5'd3:  begin ma = a_q;   mb = s_q;   end      // a*s
			5'd4:  begin ma = t_q;   mb = c1;    end
			5'd5:  begin ma = c_q;   mb = s_q;   end      // c*s
			5'd6:  begin ma = t_q;   mb = c2;    end
			5'd7:  begin ma = b_q;   mb = s_q;   end      // b*s
			5'd8:  begin ma = a_q;   mb = p1x;   end      // slope terms
			5'd9:  begin ma = c_q;   mb = p2x - p1x; end
			5'd10: begin ma = b_q;   mb = One - p2x; end
			default: ;
		endcase
		mp   = (2*VW)'(ma) * (2*VW)'(mb);
		mabs = mp[2*VW-1] ? -mp : mp;
		mabs = (mabs + Half) >>> FRAC_BITS;
		mr   = mp[2*VW-1] ? -VW'(mabs) : VW'(mabs);
	end

	// bit-serial restoring divider on magnitudes
	logic [DW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic          neg_q;
	logic [DW:0]   rem_sh;
	logic [DW-1:0] diff;
	always_comb begin
		rem_sh = {rem_q, num_q[DW-1]};
		diff   = DW'(play_time) - DW'(start_delay_q);
	end

	logic signed [VW-1:0] xmf, snew;
	logic signed [QW:0]   qs;
	logic signed [DW-1:0] xnum;
	always_comb begin
		xmf  = acc_q - f_q;
		xnum = DW'(xmf) <<< FRAC_BITS;
		qs   = neg_q ? -(QW+1)'(quo_q) : (QW+1)'(quo_q);
		snew = VW'(s_q) - VW'(qs);
		if (qs > (QW+1)'(s_q) + (QW+1)'(0) && !qs[QW] && qs > (QW+1)'(VW'(s_q)))
			snew = '0;
		if (qs[QW] && -qs > (QW+1)'(One))
			snew = One;
		if (snew < 0)
			snew = '0;
		else if (snew > One)
			snew = One;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			cbe_pkg::OP_LOAD: begin
				// diff is clamped in PROG; a full divide is run either way
				num_q  <= DW'(diff[TIME_BITS-1:0]) << FRAC_BITS;
				den_q  <= DW'(segment_length_q);
				rem_q  <= '0;
				quo_q  <= '0;
				neg_q  <= 1'b0;
				t_q    <= (diff[DW-1] || diff == '0) ? '0 :
				          (diff >= DW'(segment_length_q)) ? One : VW'(-1);
			end
			cbe_pkg::OP_DIVSTP: begin
				num_q <= num_q << 1;
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= DW'(rem_sh - {1'b0, den_q});
					quo_q <= {quo_q[QW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[DW-1:0];
					quo_q <= {quo_q[QW-2:0], 1'b0};
				end
			end
			cbe_pkg::OP_PROG: begin
				f_q   <= (t_q == VW'(-1)) ? VW'(quo_q) : t_q;
				s_q   <= (t_q == VW'(-1)) ? VW'(quo_q) : t_q;
				omt_q <= One - ((t_q == VW'(-1)) ? VW'(quo_q) : t_q);
			end
			cbe_pkg::OP_MUL: begin
				case (cmd.mstep)
					5'd0: a_q <= mr;
					5'd1: b_q <= mr;
					5'd2: c_q <= mr;
					5'd3: t_q <= mr;
					5'd4: acc_q <= mr * VW'(3);
					5'd5: t_q <= mr;
					5'd6: acc_q <= acc_q + mr * VW'(3);
					5'd7: acc_q <= acc_q + mr;
					5'd8: dx_q <= mr * VW'(3);
					5'd9: dx_q <= dx_q + mr * VW'(6);
					5'd10: begin
						dx_q <= dx_q + mr * VW'(3);
					end
					5'd11: begin
						// start delta division: |x-f|<<F / |dx|
						num_q <= xnum[DW-1] ? -xnum : xnum;
						den_q <= dx_q[VW-1] ? DW'(-dx_q) : DW'(dx_q);
						neg_q <= xnum[DW-1] ^ dx_q[VW-1];
						rem_q <= '0;
						quo_q <= '0;
					end
					default: ;
				endcase
			end
			cbe_pkg::OP_NEWTON: begin
				s_q   <= snew;
				omt_q <= One - snew;
			end
			default: ;
		endcase
	end

	logic [FRAC_BITS:0] progress_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			progress_q <= '0;
		else if (cmd.op == cbe_pkg::OP_YOUT)
			progress_q <= status.len_zero ? '0 :
			              acc_q < 0 ? '0 :
			              acc_q > One ? XW'(One) : XW'(acc_q);
	end

	assign status.len_zero = (segment_length_q == '0);
	assign status.dx_zero  = (dx_q == '0);
	assign progress        = progress_q;

endmodule

// ===== rtl/cbe_ctrl.sv =====
// Controller of the cubic Bezier easing evaluator: sequences the divider,
// the polynomial micro steps and the Newton loop. Depends on cbe_pkg.
module cbe_ctrl #(
	parameter int NEWTON_STEPS = 6,
	parameter int DIV_STEPS    = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cbe_pkg::status_t status,
	output cbe_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);

	typedef enum logic [2:0] {
		S_IDLE, S_DIV0, S_PROG, S_POLY, S_DIV1, S_NEWT, S_YPOLY, S_OUT
	} state_t;

	localparam int CW = $clog2(DIV_STEPS + 1);
	localparam int NW = $clog2(NEWTON_STEPS + 1);

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [4:0]      mstep_q;
	logic [NW-1:0]   iter_q;

	always_comb begin
		cmd.op     = cbe_pkg::OP_NONE;
		cmd.mstep  = mstep_q;
		cmd.y_pass = (state_q == S_YPOLY);
		case (state_q)
			S_IDLE:  if (start) cmd.op = cbe_pkg::OP_LOAD;
			S_DIV0, S_DIV1: cmd.op = cbe_pkg::OP_DIVSTP;
			S_PROG:  cmd.op = cbe_pkg::OP_PROG;
			S_POLY, S_YPOLY: cmd.op = cbe_pkg::OP_MUL;
			S_NEWT:  cmd.op = cbe_pkg::OP_NEWTON;
			S_OUT:   cmd.op = cbe_pkg::OP_YOUT;
			default: cmd.op = cbe_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			mstep_q <= '0;
			iter_q  <= '0;
			busy    <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					busy    <= 1'b1;
					cnt_q   <= CW'(DIV_STEPS);
					state_q <= S_DIV0;
				end
				S_DIV0: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) state_q <= S_PROG;
				end
				S_PROG: begin
					mstep_q <= '0;
					iter_q  <= '0;
					state_q <= status.len_zero ? S_OUT : S_POLY;
				end
				S_POLY: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == 5'd11) begin
						cnt_q   <= CW'(DIV_STEPS);
						state_q <= S_DIV1;
					end
				end
				default: ;
			endcase
			if (state_q == S_POLY && mstep_q == 5'd11 && status.dx_zero) begin
				mstep_q <= '0;
				state_q <= S_YPOLY;
			end
			case (state_q)
				S_DIV1: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) state_q <= S_NEWT;
				end
				S_NEWT: begin
					mstep_q <= '0;
					iter_q  <= iter_q + 1'b1;
					state_q <= (iter_q == NW'(NEWTON_STEPS - 1)) ? S_YPOLY : S_POLY;
				end
				S_YPOLY: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == 5'd7) state_q <= S_OUT;
				end
				S_OUT: begin
					busy    <= 1'b0;
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/cubic_bezier_easing_eval_unit.sv =====
// Top level of the cubic Bezier easing evaluator.
// Joins cbe_ctrl and cbe_datapath; depends on cbe_pkg.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------
//  request   | start while busy is low    | play_time
//  result    | done strobe, one cycle     | progress
//  config    | cfg_valid && cfg_ready     | cfg_index, cfg_data
//
// A request runs the progress division, then up to NEWTON_STEPS Newton
// iterations, each a polynomial pass and a delta division, then a y pass.
// A flat slope ends the Newton loop early. Reset clears control and restores
// the register defaults. The receiver cannot stall; busy holds off requests.
module cubic_bezier_easing_eval_unit #(
	parameter int NEWTON_STEPS = 6,
	parameter int FRAC_BITS    = 16,
	parameter int TIME_BITS    = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [TIME_BITS-1:0] play_time,
	output logic                 done,
	output logic [FRAC_BITS:0]   progress,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	cbe_pkg::cmd_t    cmd;
	cbe_pkg::status_t status;

	// registers are always writable
	assign cfg_ready = 1'b1;

	cbe_ctrl #(
		.NEWTON_STEPS(NEWTON_STEPS),
		.DIV_STEPS   (TIME_BITS + FRAC_BITS + 8)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	cbe_datapath #(
		.FRAC_BITS(FRAC_BITS),
		.TIME_BITS(TIME_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid),
		.cfg_idx  (cfg_index),
		.cfg_data (cfg_data),
		.play_time(play_time),
		.cmd      (cmd),
		.status   (status),
		.progress (progress)
	);

endmodule
